>>> hw/rtl/ftmc_pkg.sv
package ftmc_pkg;

	localparam int POSITION_BITS = 16;

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [2:0] mode_t;
	typedef logic [2:0] lines_t;

	localparam mode_t ST_IDLE       = 3'd0;
	localparam mode_t ST_START_DOWN = 3'd1;
	localparam mode_t ST_START_UP   = 3'd2;
	localparam mode_t ST_ESTOP      = 3'd3;
	localparam mode_t ST_UP_WRAP    = 3'd4;
	localparam mode_t ST_UP_PLAIN   = 3'd5;
	localparam mode_t ST_DOWN_WRAP  = 3'd6;
	localparam mode_t ST_DOWN_PLAIN = 3'd7;

	// Line bits: 0 left, 1 right, 2 enable.
	localparam lines_t LINES_OFF   = 3'b000;
	localparam lines_t LINES_LEFT  = 3'b101;
	localparam lines_t LINES_RIGHT = 3'b110;

	localparam logic [15:0] DISTANCE_RESET = 16'd60000;

endpackage

>>> hw/rtl/fixed_travel_motor_controller_top.sv
// Fixed-travel motor controller.
// The input channel (in_valid/in_ready) carries one sample word per tick: the
// emergency stop, resume and start buttons and the encoder position. For every
// accepted word the block returns one result word on the output channel
// (out_valid/out_ready): the left, right and enable motor lines and the mode code.
// The control state, origin, target and motor lines are updated at the edge that
// accepts a word, and the updated state registers themselves drive the result,
// so the result appears in the cycle after acceptance.
// Throughput is one word per cycle; the whole update is one compare-and-add
// level between the state registers. When the receiver stalls, the result is
// held and in_ready drops until it is taken; a word is accepted in the same
// cycle that the waiting result is taken.
// The travel distance is written on the cfg_valid/cfg_ready channel, which is
// always ready, and should only be written while the block is idle.
// Reset puts the block in idle with all motor lines off, origin and target at
// zero, the travel distance at 60000, and no result pending.
module fixed_travel_motor_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        emergency_stop,
	input  logic        resume_button,
	input  logic        start_up_request,
	input  logic        start_down_request,
	input  logic [15:0] position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        motor_left,
	output logic        motor_right,
	output logic        motor_enable,
	output logic [2:0]  mode_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] travel_distance
);

	ftmc_pkg::mode_t  state_q, state_d;
	ftmc_pkg::lines_t lines_q, lines_d;
	ftmc_pkg::pos_t   origin_q, origin_d;
	ftmc_pkg::pos_t   target_q, target_d;
	logic [15:0]      distance_q;
	logic             out_valid_q;
	logic             in_accept;
	ftmc_pkg::pos_t   pos;
	ftmc_pkg::pos_t   distance;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign pos      = ftmc_pkg::pos_t'(position);
	assign distance = ftmc_pkg::pos_t'(distance_q);

	always_comb begin
		state_d  = state_q;
		lines_d  = lines_q;
		origin_d = origin_q;
		target_d = target_q;
		if (state_q != ftmc_pkg::ST_ESTOP && emergency_stop) begin
			state_d = ftmc_pkg::ST_ESTOP;
			lines_d = ftmc_pkg::LINES_OFF;
		end else begin
			unique case (state_q)
				ftmc_pkg::ST_IDLE: begin
					if (start_up_request && !start_down_request) begin
						state_d = ftmc_pkg::ST_START_UP;
					end else if (!start_up_request && start_down_request) begin
						state_d = ftmc_pkg::ST_START_DOWN;
					end
				end
				ftmc_pkg::ST_START_UP: begin
					state_d = (pos >= target_q) ? ftmc_pkg::ST_UP_PLAIN
						: ftmc_pkg::ST_UP_WRAP;
					lines_d = ftmc_pkg::LINES_LEFT;
				end
				ftmc_pkg::ST_START_DOWN: begin
					state_d = (pos > target_q) ? ftmc_pkg::ST_DOWN_WRAP
						: ftmc_pkg::ST_DOWN_PLAIN;
					lines_d = ftmc_pkg::LINES_RIGHT;
				end
				ftmc_pkg::ST_ESTOP: begin
					if (resume_button && !emergency_stop) begin
						state_d = ftmc_pkg::ST_IDLE;
						lines_d = ftmc_pkg::LINES_OFF;
					end
				end
				ftmc_pkg::ST_UP_WRAP: begin
					if (pos < target_q && pos > origin_q) begin
						state_d = ftmc_pkg::ST_IDLE;
						lines_d = ftmc_pkg::LINES_OFF;
					end else if (start_up_request) begin
						state_d = ftmc_pkg::ST_START_UP;
					end
				end
				ftmc_pkg::ST_UP_PLAIN: begin
					if (pos < target_q || pos > origin_q) begin
						state_d = ftmc_pkg::ST_IDLE;
						lines_d = ftmc_pkg::LINES_OFF;
					end else if (start_up_request) begin
						state_d = ftmc_pkg::ST_START_UP;
					end
				end
				ftmc_pkg::ST_DOWN_WRAP: begin
					if (pos > target_q && pos < origin_q) begin
						state_d = ftmc_pkg::ST_IDLE;
						lines_d = ftmc_pkg::LINES_OFF;
					end else if (start_down_request) begin
						state_d = ftmc_pkg::ST_START_DOWN;
					end
				end
				default: begin
					if (pos > target_q || pos < origin_q) begin
						state_d = ftmc_pkg::ST_IDLE;
						lines_d = ftmc_pkg::LINES_OFF;
					end else if (start_down_request) begin
						state_d = ftmc_pkg::ST_START_DOWN;
					end
				end
			endcase
			// Entering a start state latches a new origin and target.
			if (state_d == ftmc_pkg::ST_START_UP) begin
				lines_d  = ftmc_pkg::LINES_LEFT;
				origin_d = pos;
				target_d = pos - distance;
			end else if (state_d == ftmc_pkg::ST_START_DOWN) begin
				lines_d  = ftmc_pkg::LINES_RIGHT;
				origin_d = pos;
				target_d = pos + distance;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftmc_pkg::ST_IDLE;
			lines_q     <= ftmc_pkg::LINES_OFF;
			origin_q    <= '0;
			target_q    <= '0;
			distance_q  <= ftmc_pkg::DISTANCE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				distance_q <= travel_distance;
			end
			if (in_accept) begin
				state_q     <= state_d;
				lines_q     <= lines_d;
				origin_q    <= origin_d;
				target_q    <= target_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign motor_left   = lines_q[0];
	assign motor_right  = lines_q[1];
	assign motor_enable = lines_q[2];
	assign mode_code    = state_q;

	a_stop_forces_estop: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && emergency_stop |=> mode_code == ftmc_pkg::ST_ESTOP && !motor_enable)
		else $error("emergency stop did not force the stop state with lines off");

	a_lines_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		!(motor_left && motor_right) && (motor_enable == (motor_left || motor_right)))
		else $error("motor lines drive both directions or enable mismatches");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_accept |=> $stable(mode_code) && $stable(lines_q))
		else $error("control state changed without an accepted word");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while a result is still waiting");

endmodule
